// ===== hdl/vmc_pkg.sv =====
package vmc_pkg;

   localparam int TIME_W     = 14;
   localparam int MINUTE_W   = 11;
   localparam int LEVEL_W    = 16;
   localparam int MODE_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 8;

   localparam int MINUTES_PER_DAY = 1440;

   // tenths to whole minutes: floor(t * 6554 / 2^16) is exact for t < 16384
   localparam int DIV10_MUL_W   = 13;
   localparam int DIV10_SHIFT   = 16;
   localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 13'd6554;

   localparam logic [MODE_W-1:0] MODE_HOLD      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TIMED     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_HUMIDITY  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_HUM_TRIG  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TEMP      = 3'd4;
   localparam logic [MODE_W-1:0] MODE_TEMP_TRIG = 3'd5;
   localparam logic [MODE_W-1:0] MODE_HOLD_ALT  = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE     = 3'd7;

   localparam logic [CSR_IDX_W-1:0] REG_MODE           = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_MINUTE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_MINUTES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HUMIDITY_LOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HUMIDITY_HIGH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_LOW       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_HIGH      = 3'd6;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic [MINUTE_W-1:0]        start_minute;
      logic [MINUTE_W-1:0]        window_minutes;
      logic [LEVEL_W-1:0]         humidity_low;
      logic [LEVEL_W-1:0]         humidity_high;
      logic signed [LEVEL_W-1:0]  temp_low;
      logic signed [LEVEL_W-1:0]  temp_high;
   } cfg_type;

   typedef struct packed {
      logic                 valve;
      logic [MINUTE_W-1:0]  window_begin;
      logic                 humidity_latch;
      logic                 heat_latch;
   } ctl_state_type;

   typedef struct packed {
      logic [TIME_W-1:0]          time_tenths;
      logic [LEVEL_W-1:0]         humidity_level;
      logic signed [LEVEL_W-1:0]  temperature_level;
   } sample_type;

endpackage

// ===== hdl/vmc_decide.sv =====
module vmc_decide (
   input  vmc_pkg::cfg_type        cfg,
   input  vmc_pkg::ctl_state_type  cur,
   input  vmc_pkg::sample_type     sample,
   output vmc_pkg::ctl_state_type  nxt
);

   localparam int LO_W  = vmc_pkg::MINUTE_W + 4;
   localparam int SUM_W = vmc_pkg::MINUTE_W + 1;
   localparam int HI_W  = SUM_W + 4;
   localparam int PROD_W = vmc_pkg::TIME_W + vmc_pkg::DIV10_MUL_W;

   logic [LO_W-1:0]   lo_tenths;
   logic [SUM_W-1:0]  end_minute;
   logic [HI_W-1:0]   hi_tenths;
   logic              in_window;
   logic [PROD_W-1:0] div_prod;
   logic [vmc_pkg::MINUTE_W-1:0] now_minute;
   logic              hum_low;
   logic              hum_high;
   logic              temp_low;
   logic              temp_high;

   // times ten as shift-add
   assign lo_tenths  = {1'b0, cur.window_begin, 3'b000} + {3'b000, cur.window_begin, 1'b0};
   assign end_minute = {1'b0, cur.window_begin} + {1'b0, cfg.window_minutes};
   assign hi_tenths  = {1'b0, end_minute, 3'b000} + {3'b000, end_minute, 1'b0};

   // window is open at both ends, no wrap past midnight
   assign in_window = ({1'b0, sample.time_tenths} > lo_tenths) &&
                      ({2'b00, sample.time_tenths} < hi_tenths);

   assign div_prod   = PROD_W'(sample.time_tenths) * PROD_W'(vmc_pkg::DIV10_MUL);
   assign now_minute = div_prod[vmc_pkg::DIV10_SHIFT +: vmc_pkg::MINUTE_W];

   assign hum_low   = sample.humidity_level < cfg.humidity_low;
   assign hum_high  = sample.humidity_level > cfg.humidity_high;
   assign temp_low  = sample.temperature_level < cfg.temp_low;
   assign temp_high = sample.temperature_level > cfg.temp_high;

   always_comb begin
      nxt = cur;
      case (cfg.mode)
         vmc_pkg::MODE_TIMED: begin
            nxt.valve = in_window;
         end
         vmc_pkg::MODE_HUMIDITY: begin
            if (hum_low) nxt.valve = 1'b1;
            if (hum_high) nxt.valve = 1'b0;
         end
         vmc_pkg::MODE_HUM_TRIG: begin
            nxt.valve = in_window;
            if (!in_window) nxt.humidity_latch = 1'b0;
            if (hum_low && nxt.humidity_latch == 1'b0) begin
               nxt.humidity_latch = 1'b1;
               nxt.window_begin   = now_minute;
            end
         end
         vmc_pkg::MODE_TEMP: begin
            if (temp_high) nxt.valve = 1'b1;
            if (temp_low) nxt.valve = 1'b0;
         end
         vmc_pkg::MODE_TEMP_TRIG: begin
            nxt.valve = in_window;
            if (!in_window) nxt.heat_latch = 1'b0;
            if (temp_high && nxt.heat_latch == 1'b0) begin
               nxt.heat_latch   = 1'b1;
               nxt.window_begin = now_minute;
            end
         end
         default: begin
            // hold modes keep the valve as it is
            nxt = cur;
         end
      endcase
   end

endmodule

// ===== hdl/valve_mode_controller_core.sv =====
// a request waits in the input register, then is decided into the response register
// throughput: one request per cycle unless the response is stalled; single decision stage
// a stalled response holds its register while one more request waits in the input register
// reset: synchronous, active high; clears configuration, valve, window start and latches
// valve is also cleared by a write to the mode register
module valve_mode_controller_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // time_tenths [13:0], humidity_level [29:14], temperature_level [45:30], zero [47:46]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // valve_on [0], zero [7:1]
   output logic [7:0]  rsp_tdata,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   vmc_pkg::cfg_type        cfg_ff, cfg_in;
   vmc_pkg::ctl_state_type  state_ff, state_in, state_next;
   vmc_pkg::sample_type     sample_ff, sample_in;
   logic                    s0_valid_ff, s0_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_valve_ff, rsp_valve_in;
   logic                    rsp_free;
   logic                    s0_advance;
   logic                    req_take;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s0_advance = s0_valid_ff && rsp_free;
   assign req_tready = !s0_valid_ff || rsp_free;
   assign req_take   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_valve_ff};

   vmc_decide u_decide (
      .cfg    (cfg_ff),
      .cur    (state_ff),
      .sample (sample_ff),
      .nxt    (state_next)
   );

   always_comb begin
      cfg_in   = cfg_ff;
      state_in = state_ff;
      if (s0_advance) state_in = state_next;
      if (csr_wen) begin
         case (csr_index)
            vmc_pkg::REG_MODE: begin
               cfg_in.mode    = csr_wdata[vmc_pkg::MODE_W-1:0];
               state_in.valve = 1'b0;
            end
            vmc_pkg::REG_START_MINUTE: begin
               cfg_in.start_minute   = csr_wdata[vmc_pkg::MINUTE_W-1:0];
               state_in.window_begin = csr_wdata[vmc_pkg::MINUTE_W-1:0];
            end
            vmc_pkg::REG_WINDOW_MINUTES: cfg_in.window_minutes = csr_wdata[vmc_pkg::MINUTE_W-1:0];
            vmc_pkg::REG_HUMIDITY_LOW:   cfg_in.humidity_low   = csr_wdata;
            vmc_pkg::REG_HUMIDITY_HIGH:  cfg_in.humidity_high  = csr_wdata;
            vmc_pkg::REG_TEMP_LOW:       cfg_in.temp_low       = csr_wdata;
            vmc_pkg::REG_TEMP_HIGH:      cfg_in.temp_high      = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      s0_valid_in = s0_valid_ff;
      sample_in   = sample_ff;
      if (s0_advance) s0_valid_in = 1'b0;
      if (req_take) begin
         s0_valid_in                 = 1'b1;
         sample_in.time_tenths       = req_tdata[13:0];
         sample_in.humidity_level    = req_tdata[29:14];
         sample_in.temperature_level = req_tdata[45:30];
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_valve_in = rsp_valve_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (s0_advance) begin
         rsp_valid_in = 1'b1;
         rsp_valve_in = state_next.valve;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         state_ff     <= '0;
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         s0_valid_ff  <= s0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      rsp_valve_ff <= rsp_valve_in;
   end

   // a decided request always lands in the response register
   assert property (@(posedge clock) disable iff (reset)
      s0_advance |=> rsp_tvalid)
      else $error("decided request lost");

   // input register only blocks when it is full and the response is stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s0_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input blocked without backpressure");

   // mode write clears the valve
   assert property (@(posedge clock) disable iff (reset)
      (csr_wen && csr_index == vmc_pkg::REG_MODE) |=> !state_ff.valve)
      else $error("valve not cleared on mode write");

   // hold modes report the valve unchanged
   assert property (@(posedge clock) disable iff (reset)
      (s0_advance && !csr_wen &&
       (cfg_ff.mode == vmc_pkg::MODE_HOLD || cfg_ff.mode == vmc_pkg::MODE_HOLD_ALT ||
        cfg_ff.mode == vmc_pkg::MODE_SPARE))
      |=> (rsp_tdata[0] == $past(state_ff.valve)))
      else $error("valve moved in hold mode");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int TENTHS_PER_MINUTE = 10;
   localparam int RANDOM_REQUESTS   = 1200;
   localparam int LONG_HOLD_CYCLES  = 400;
   localparam int SETTLE_CYCLES     = 6;
   localparam int PRINT_LIMIT       = 40;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_wen    = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   // tracks configuration and controller state, and holds the valve values still to come
   class valve_tracker;
      vmc_pkg::cfg_type       cfg;
      vmc_pkg::ctl_state_type ctl;
      bit                     expected_valve[$];
      int                     mismatch_count;
      int                     response_count;

      function new();
         cfg            = '0;
         ctl            = '0;
         mismatch_count = 0;
         response_count = 0;
      endfunction

      function void write_register(logic [2:0] index, logic [15:0] value);
         case (index)
            vmc_pkg::REG_MODE: begin
               cfg.mode  = value[vmc_pkg::MODE_W-1:0];
               ctl.valve = 1'b0;
            end
            vmc_pkg::REG_START_MINUTE: begin
               cfg.start_minute = value[vmc_pkg::MINUTE_W-1:0];
               ctl.window_begin = value[vmc_pkg::MINUTE_W-1:0];
            end
            vmc_pkg::REG_WINDOW_MINUTES: cfg.window_minutes = value[vmc_pkg::MINUTE_W-1:0];
            vmc_pkg::REG_HUMIDITY_LOW:   cfg.humidity_low   = value;
            vmc_pkg::REG_HUMIDITY_HIGH:  cfg.humidity_high  = value;
            vmc_pkg::REG_TEMP_LOW:       cfg.temp_low       = value;
            vmc_pkg::REG_TEMP_HIGH:      cfg.temp_high      = value;
            default: ;
         endcase
      endfunction

      // open interval in tenths, no wrap at midnight
      function bit in_watering_window(int unsigned t);
         int unsigned lo;
         int unsigned hi;
         lo = int'(ctl.window_begin) * TENTHS_PER_MINUTE;
         hi = (int'(ctl.window_begin) + int'(cfg.window_minutes)) * TENTHS_PER_MINUTE;
         return t > lo && t < hi;
      endfunction

      function void note_request(vmc_pkg::sample_type s);
         int unsigned t;
         int unsigned now_minute;
         bit          open;
         t          = s.time_tenths;
         now_minute = t / TENTHS_PER_MINUTE;
         open       = in_watering_window(t);
         case (cfg.mode)
            vmc_pkg::MODE_TIMED: ctl.valve = open;
            vmc_pkg::MODE_HUMIDITY: begin
               if (s.humidity_level < cfg.humidity_low)  ctl.valve = 1'b1;
               if (s.humidity_level > cfg.humidity_high) ctl.valve = 1'b0;
            end
            vmc_pkg::MODE_HUM_TRIG: begin
               ctl.valve = open;
               if (!open) ctl.humidity_latch = 1'b0;
               // restart takes effect on the next request
               if (s.humidity_level < cfg.humidity_low && !ctl.humidity_latch) begin
                  ctl.humidity_latch = 1'b1;
                  ctl.window_begin   = now_minute[vmc_pkg::MINUTE_W-1:0];
               end
            end
            vmc_pkg::MODE_TEMP: begin
               if ($signed(s.temperature_level) > $signed(cfg.temp_high)) ctl.valve = 1'b1;
               if ($signed(s.temperature_level) < $signed(cfg.temp_low))  ctl.valve = 1'b0;
            end
            vmc_pkg::MODE_TEMP_TRIG: begin
               ctl.valve = open;
               if (!open) ctl.heat_latch = 1'b0;
               if ($signed(s.temperature_level) > $signed(cfg.temp_high) && !ctl.heat_latch) begin
                  ctl.heat_latch   = 1'b1;
                  ctl.window_begin = now_minute[vmc_pkg::MINUTE_W-1:0];
               end
            end
            default: ;
         endcase
         expected_valve.push_back(ctl.valve);
      endfunction

      task report_mismatch(string what);
         mismatch_count++;
         if (mismatch_count <= PRINT_LIMIT) $display("mismatch at %0t: %s", $time, what);
      endtask

      task check_response(logic valve_on);
         bit want;
         response_count++;
         if (expected_valve.size() == 0) begin
            report_mismatch($sformatf("valve_on=%0b with no request waiting", valve_on));
         end else begin
            want = expected_valve.pop_front();
            if (valve_on !== want) begin
               report_mismatch($sformatf("response %0d: valve_on=%0b, expected %0b",
                                         response_count, valve_on, want));
            end
         end
      endtask
   endclass

   valve_tracker        tracker = new();
   vmc_pkg::sample_type request_queue[$];
   bit                  long_hold_request = 1'b0;
   int                  gap_style         = 0;
   int                  ready_kind        = 0;
   int                  ready_left        = 0;
   int                  ready_period      = 2;
   int                  ready_phase       = 0;
   int                  requests_sent     = 0;
   int                  settings_used     = 0;
   bit [7:0]            modes_seen        = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   valve_mode_controller_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata[0]);
   end

   // receiver stall pattern: segments of always ready, coin flip, mostly stalled, periodic
   function bit next_ready();
      if (ready_left == 0) begin
         ready_kind   = $urandom_range(0, 3);
         ready_left   = $urandom_range(1, 60);
         ready_period = $urandom_range(2, 6);
      end
      ready_left--;
      ready_phase++;
      case (ready_kind)
         0:       return 1'b1;
         1:       return 1'($urandom_range(0, 1));
         2:       return $urandom_range(0, 3) == 0;
         default: return (ready_phase % ready_period) == 0;
      endcase
   endfunction

   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= next_ready();
      end
   end

   initial begin
      #5_000_000;
      $display("timed out waiting for the block");
      $display("== FAIL ==");
      $finish;
   end

   task automatic write_csr(logic [2:0] index, logic [15:0] value);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_register(index, value);
      if (index == vmc_pkg::REG_MODE) modes_seen[value[vmc_pkg::MODE_W-1:0]] = 1'b1;
   endtask

   function automatic void queue_item(int unsigned t, logic [15:0] hum, logic [15:0] temp);
      vmc_pkg::sample_type s;
      s.time_tenths       = t[vmc_pkg::TIME_W-1:0];
      s.humidity_level    = hum;
      s.temperature_level = temp;
      request_queue.push_back(s);
   endfunction

   function automatic logic [15:0] near_level(logic [15:0] level);
      return level + 16'($urandom_range(0, 8)) - 16'd4;
   endfunction

   task automatic wait_idle();
      while (tracker.expected_valve.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic drive_requests();
      int                  burst_left;
      int                  gap;
      vmc_pkg::sample_type s;
      burst_left = 0;
      while (request_queue.size() != 0) begin
         if (burst_left == 0) begin
            case (gap_style)
               0:       gap = 0;
               1:       gap = $urandom_range(0, 3);
               default: gap = $urandom_range(0, 20);
            endcase
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 24);
         end
         s = request_queue.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= {2'b00, s.temperature_level, s.humidity_level, s.time_tenths};
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         tracker.note_request(s);
         requests_sent++;
         burst_left--;
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic apply_random_settings(bit write_every);
      logic [15:0] value [7];
      int          order [7];
      int          pick;
      int          j;
      int          k;
      pick = $urandom_range(0, 7);
      value[vmc_pkg::REG_MODE] = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) :
                                 16'($urandom_range(1, 5));
      value[vmc_pkg::REG_START_MINUTE] = (pick == 0) ? 16'd0 :
                                         (pick == 1) ? 16'd1439 : 16'($urandom_range(0, 1439));
      value[vmc_pkg::REG_WINDOW_MINUTES] = (pick == 2) ? 16'd0 :
                                           (pick == 3) ? 16'd1439 : 16'($urandom_range(1, 40));
      value[vmc_pkg::REG_HUMIDITY_LOW] = (pick == 4) ? 16'hffff :
                                         (pick == 5) ? 16'h0000 : 16'($urandom);
      value[vmc_pkg::REG_HUMIDITY_HIGH] = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
            value[vmc_pkg::REG_HUMIDITY_LOW] + 16'($urandom_range(0, 3000));
      value[vmc_pkg::REG_TEMP_LOW] = (pick == 4) ? 16'h8000 :
                                     (pick == 5) ? 16'h7fff : 16'($urandom);
      value[vmc_pkg::REG_TEMP_HIGH] = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
            value[vmc_pkg::REG_TEMP_LOW] + 16'($urandom_range(0, 3000));
      for (int i = 0; i < 7; i++) order[i] = i;
      for (int i = 6; i > 0; i--) begin
         j        = $urandom_range(0, i);
         k        = order[i];
         order[i] = order[j];
         order[j] = k;
      end
      for (int i = 0; i < 7; i++) begin
         if (write_every || $urandom_range(0, 1)) write_csr(3'(order[i]), value[order[i]]);
      end
      csr_wen <= 1'b0;
      settings_used++;
   endtask

   // mostly a running clock of day with readings near the thresholds, some noise
   task automatic queue_random_requests(int count);
      int unsigned t;
      logic [15:0] hum;
      logic [15:0] temp;
      t = int'(tracker.cfg.start_minute) * TENTHS_PER_MINUTE;
      t = (t > 150) ? t - $urandom_range(0, 150) : $urandom_range(0, 50);
      repeat (count) begin
         if ($urandom_range(0, 6) == 0) begin
            queue_item($urandom_range(0, 16383), 16'($urandom), 16'($urandom));
         end else begin
            t = t + $urandom_range(0, 25);
            if (t > 16383) t = $urandom_range(0, 30);
            case ($urandom_range(0, 3))
               0:       hum = near_level(tracker.cfg.humidity_low);
               1:       hum = near_level(tracker.cfg.humidity_high);
               default: hum = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
               0:       temp = near_level(tracker.cfg.temp_low);
               1:       temp = near_level(tracker.cfg.temp_high);
               default: temp = 16'($urandom);
            endcase
            queue_item(t, hum, temp);
         end
      end
   endtask

   task automatic run_directed();
      // timed window: both ends open, time extremes
      write_csr(vmc_pkg::REG_START_MINUTE, 16'd100);
      write_csr(vmc_pkg::REG_WINDOW_MINUTES, 16'd10);
      write_csr(vmc_pkg::REG_MODE, 16'(vmc_pkg::MODE_TIMED));
      csr_wen <= 1'b0;
      queue_item(1000, 16'($urandom), 16'($urandom));
      queue_item(1001, 16'($urandom), 16'($urandom));
      queue_item(1099, 16'($urandom), 16'($urandom));
      queue_item(1100, 16'($urandom), 16'($urandom));
      queue_item(0, 16'($urandom), 16'($urandom));
      queue_item(16383, 16'($urandom), 16'($urandom));
      drive_requests();
      wait_idle();

      // window running past midnight
      write_csr(vmc_pkg::REG_START_MINUTE, 16'd1430);
      write_csr(vmc_pkg::REG_WINDOW_MINUTES, 16'd20);
      csr_wen <= 1'b0;
      queue_item(14399, 16'($urandom), 16'($urandom));
      queue_item(14499, 16'($urandom), 16'($urandom));
      queue_item(16383, 16'($urandom), 16'($urandom));
      drive_requests();
      wait_idle();

      // humidity hysteresis, equal readings change nothing
      write_csr(vmc_pkg::REG_HUMIDITY_LOW, 16'd1000);
      write_csr(vmc_pkg::REG_HUMIDITY_HIGH, 16'd2000);
      write_csr(vmc_pkg::REG_MODE, 16'(vmc_pkg::MODE_HUMIDITY));
      csr_wen <= 1'b0;
      queue_item($urandom_range(0, 14399), 16'd999, 16'h8000);
      queue_item($urandom_range(0, 14399), 16'd2000, 16'h7fff);
      queue_item($urandom_range(0, 14399), 16'd2001, 16'h8000);
      drive_requests();
      wait_idle();
      // crossed thresholds: the off test wins
      write_csr(vmc_pkg::REG_HUMIDITY_LOW, 16'd5000);
      write_csr(vmc_pkg::REG_HUMIDITY_HIGH, 16'd3000);
      csr_wen <= 1'b0;
      queue_item($urandom_range(0, 14399), 16'd4000, 16'h7fff);
      drive_requests();
      wait_idle();

      // temperature hysteresis, signed thresholds
      write_csr(vmc_pkg::REG_TEMP_LOW, 16'(-100));
      write_csr(vmc_pkg::REG_TEMP_HIGH, 16'd100);
      write_csr(vmc_pkg::REG_MODE, 16'(vmc_pkg::MODE_TEMP));
      csr_wen <= 1'b0;
      queue_item($urandom_range(0, 14399), 16'hffff, 16'd101);
      queue_item($urandom_range(0, 14399), 16'h0000, 16'(-100));
      queue_item($urandom_range(0, 14399), 16'hffff, 16'(-101));
      queue_item($urandom_range(0, 14399), 16'h0000, 16'd100);
      drive_requests();
      wait_idle();

      // humidity-triggered restart, decided on the old window first
      write_csr(vmc_pkg::REG_START_MINUTE, 16'd50);
      write_csr(vmc_pkg::REG_WINDOW_MINUTES, 16'd5);
      write_csr(vmc_pkg::REG_HUMIDITY_LOW, 16'd1000);
      write_csr(vmc_pkg::REG_MODE, 16'(vmc_pkg::MODE_HUM_TRIG));
      csr_wen <= 1'b0;
      queue_item(505, 16'd500, 16'($urandom));
      queue_item(600, 16'd500, 16'($urandom));
      queue_item(605, 16'd2000, 16'($urandom));
      drive_requests();
      wait_idle();

      // temperature-triggered restart held off by the latch
      write_csr(vmc_pkg::REG_START_MINUTE, 16'd50);
      write_csr(vmc_pkg::REG_MODE, 16'(vmc_pkg::MODE_TEMP_TRIG));
      csr_wen <= 1'b0;
      queue_item(505, 16'($urandom), 16'd200);
      queue_item(506, 16'($urandom), 16'd200);
      queue_item(560, 16'($urandom), 16'd200);
      drive_requests();
      wait_idle();

      // unused mode code holds
      write_csr(vmc_pkg::REG_MODE, 16'(vmc_pkg::MODE_SPARE));
      csr_wen <= 1'b0;
      queue_item(555, 16'd0, 16'h7fff);
      drive_requests();
      wait_idle();
      settings_used += 7;
   endtask

   initial begin
      int phase;
      int phase_items;
      int random_target;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_style = 1;
      run_directed();

      phase         = 0;
      random_target = requests_sent + RANDOM_REQUESTS;
      while (requests_sent < random_target) begin
         wait_idle();
         apply_random_settings(phase == 0);
         gap_style   = $urandom_range(0, 2);
         phase_items = $urandom_range(10, 50);
         if (phase == 4) begin
            // receiver goes quiet while the sender keeps pushing
            long_hold_request = 1'b1;
            gap_style         = 0;
            phase_items       = 60;
         end
         queue_random_requests(phase_items);
         drive_requests();
         phase++;
      end
      wait_idle();

      $display("checked %0d valve responses for %0d requests under %0d register settings",
               tracker.response_count, requests_sent, settings_used);
      $display("mode codes written %b, mismatches %0d", modes_seen, tracker.mismatch_count);
      if (tracker.mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/vmc_pkg.sv
hdl/vmc_decide.sv
hdl/valve_mode_controller_core.sv
sim/tb.sv
